// File: src/mi_pkg.sv
// ----------------------------------------------------------------------------
// mi_pkg
// Shared types, constants and the microcode table of the modular inverse.
// ----------------------------------------------------------------------------
`default_nettype none

package mi_pkg;

   localparam int WIDTH_DEFAULT = 32;
   localparam int STEP_W        = 4;

   typedef logic [STEP_W-1:0] step_type;

   // program steps
   localparam step_type ST_IDLE     = 4'd0;
   localparam step_type ST_CHK_ONE  = 4'd1;
   localparam step_type ST_CHK_ZERO = 4'd2;
   localparam step_type ST_LOOP     = 4'd3;
   localparam step_type ST_DINIT    = 4'd4;
   localparam step_type ST_DSTEP    = 4'd5;
   localparam step_type ST_UPDATE   = 4'd6;
   localparam step_type ST_END      = 4'd7;
   localparam step_type ST_FIX      = 4'd8;
   localparam step_type ST_ONE      = 4'd9;
   localparam step_type ST_FAIL     = 4'd10;
   localparam step_type ST_EMIT     = 4'd15;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_DINIT,
      OP_DSTEP,
      OP_UPDATE,
      OP_FIX,
      OP_ONE,
      OP_FAIL,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      C_NONE,
      C_ALWAYS,
      C_NO_REQ,
      C_MOD_ONE,
      C_TRIV_FAIL,
      C_LOOP_DONE,
      C_DIV_MORE,
      C_NOT_ONE,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic mod_one;
      logic triv_fail;
      logic loop_done;
      logic div_more;
      logic not_one;
      logic out_busy;
   } status_type;

   // control store; the last step falls through to the first
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      case (step)
         ST_IDLE:     w = '{OP_LOAD,   C_NO_REQ,    ST_IDLE};
         ST_CHK_ONE:  w = '{OP_NOP,    C_MOD_ONE,   ST_ONE};
         ST_CHK_ZERO: w = '{OP_NOP,    C_TRIV_FAIL, ST_FAIL};
         ST_LOOP:     w = '{OP_NOP,    C_LOOP_DONE, ST_END};
         ST_DINIT:    w = '{OP_DINIT,  C_NONE,      ST_IDLE};
         ST_DSTEP:    w = '{OP_DSTEP,  C_DIV_MORE,  ST_DSTEP};
         ST_UPDATE:   w = '{OP_UPDATE, C_ALWAYS,    ST_LOOP};
         ST_END:      w = '{OP_NOP,    C_NOT_ONE,   ST_FAIL};
         ST_FIX:      w = '{OP_FIX,    C_ALWAYS,    ST_EMIT};
         ST_ONE:      w = '{OP_ONE,    C_ALWAYS,    ST_EMIT};
         ST_FAIL:     w = '{OP_FAIL,   C_ALWAYS,    ST_EMIT};
         ST_EMIT:     w = '{OP_EMIT,   C_OUT_BUSY,  ST_EMIT};
         default:     w = '{OP_NOP,    C_ALWAYS,    ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: src/mi_if.sv
// ----------------------------------------------------------------------------
// mi_if
// Valid/ready channels for request values and inverse responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface mi_req_if #(parameter int WIDTH = mi_pkg::WIDTH_DEFAULT);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface mi_rsp_if #(parameter int WIDTH = mi_pkg::WIDTH_DEFAULT);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] inverse;
   logic             no_inverse;

   modport source (output valid, output inverse, output no_inverse, input ready);
   modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

`default_nettype wire

// File: src/mi_useq.sv
// ----------------------------------------------------------------------------
// mi_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module mi_useq (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire mi_pkg::status_type status,
   output mi_pkg::ucode_type  ctrl
);
   import mi_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     jump;

   always_comb begin
      ctrl = ucode_rom(pc_ff);
   end

   always_comb begin
      case (ctrl.cond)
         C_NONE:      jump = 1'b0;
         C_ALWAYS:    jump = 1'b1;
         C_NO_REQ:    jump = !status.req_valid;
         C_MOD_ONE:   jump = status.mod_one;
         C_TRIV_FAIL: jump = status.triv_fail;
         C_LOOP_DONE: jump = status.loop_done;
         C_DIV_MORE:  jump = status.div_more;
         C_NOT_ONE:   jump = status.not_one;
         C_OUT_BUSY:  jump = status.out_busy;
         default:     jump = 1'b1;
      endcase
      pc_in = jump ? ctrl.target : pc_ff + step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// File: src/mi_datapath.sv
// ----------------------------------------------------------------------------
// mi_datapath
// Remainder pair, Bezout coefficients, bit-serial divider and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mi_datapath #(
   parameter int WIDTH = mi_pkg::WIDTH_DEFAULT
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic csr_write,
   input  wire                logic [WIDTH-1:0] csr_wdata,
   input  wire mi_pkg::ucode_type  ctrl,
   output mi_pkg::status_type status,
   mi_req_if.sink             req,
   mi_rsp_if.source           rsp
);
   import mi_pkg::*;

   localparam int CW    = WIDTH + 2;
   localparam int CNT_W = $clog2(WIDTH);
   localparam logic [CNT_W-1:0] CntLast = CNT_W'(WIDTH - 1);

   logic [WIDTH-1:0] mod_ff;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [CW-1:0]    keep_ff, keep_in;
   logic [CW-1:0]    lead_ff, lead_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [CW-1:0]    prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic             fail_ff, fail_in;
   logic             rvalid_ff, rvalid_in;
   logic [WIDTH-1:0] rinv_ff, rinv_in;
   logic             rfail_ff, rfail_in;

   logic [WIDTH:0]   rem_sh;
   logic             ge;
   logic [WIDTH:0]   rem_sub;
   logic [CW-1:0]    fix_sum;
   logic             emit;

   assign req.ready      = (ctrl.op == OP_LOAD);
   assign rsp.valid      = rvalid_ff;
   assign rsp.inverse    = rinv_ff;
   assign rsp.no_inverse = rfail_ff;

   always_comb begin
      status.req_valid = req.valid;
      status.mod_one   = (mod_ff == WIDTH'(1));
      status.triv_fail = (mod_ff == '0) || (a_ff == '0);
      status.loop_done = !((a_ff > WIDTH'(1)) && (b_ff != '0));
      status.div_more  = (cnt_ff != CntLast);
      status.not_one   = (a_ff != WIDTH'(1));
      status.out_busy  = rvalid_ff && !rsp.ready;
   end

   // restoring division step, quotient bit folded into q * keep
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[WIDTH-1]};
      ge      = (rem_sh >= {1'b0, b_ff});
      rem_sub = rem_sh - {1'b0, b_ff};
      fix_sum = lead_ff + (lead_ff[CW-1] ? {2'b00, mod_ff} : '0);
      emit    = (ctrl.op == OP_EMIT) && !status.out_busy;
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      keep_in = keep_ff;
      lead_in = lead_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      fail_in = fail_ff;
      case (ctrl.op)
         OP_LOAD: begin
            a_in    = req.value;
            b_in    = mod_ff;
            keep_in = '0;
            lead_in = CW'(1);
         end
         OP_DINIT: begin
            rem_in  = '0;
            dvd_in  = a_ff;
            prod_in = '0;
            cnt_in  = '0;
         end
         OP_DSTEP: begin
            rem_in  = ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
            dvd_in  = {dvd_ff[WIDTH-2:0], 1'b0};
            prod_in = {prod_ff[CW-2:0], 1'b0} + (ge ? keep_ff : '0);
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         OP_UPDATE: begin
            a_in    = b_ff;
            b_in    = rem_ff;
            keep_in = lead_ff - prod_ff;
            lead_in = keep_ff;
         end
         OP_FIX: begin
            res_in  = fix_sum[WIDTH-1:0];
            fail_in = 1'b0;
         end
         OP_ONE: begin
            res_in  = WIDTH'(1);
            fail_in = 1'b0;
         end
         OP_FAIL: begin
            res_in  = '0;
            fail_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rvalid_in = rvalid_ff && !rsp.ready;
      rinv_in   = rinv_ff;
      rfail_in  = rfail_ff;
      if (emit) begin
         rvalid_in = 1'b1;
         rinv_in   = res_ff;
         rfail_in  = fail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff    <= WIDTH'(1);
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            mod_ff <= csr_wdata;
         end
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      keep_ff  <= keep_in;
      lead_ff  <= lead_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      prod_ff  <= prod_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
      fail_ff  <= fail_in;
      rinv_ff  <= rinv_in;
      rfail_ff <= rfail_in;
   end

endmodule

`default_nettype wire

// File: src/modular_inverse.sv
// Sequence: a modulus of 1 answers 1 and a modulus or value of 0 answers no inverse
//   without entering the loop; otherwise the extended Euclid loop runs to completion.
// Flow: one item in work at a time; the next transfer can be taken in the same cycle
//   that response valid rises, once the sequencer is back in its idle step.
// Each iteration runs a bit-serial divider, one quotient bit per cycle.
// Reset: synchronous, clears the sequencer and response valid, modulus to 1.
// ----------------------------------------------------------------------------
// modular_inverse
// Modular inverse by extended Euclid under a microcoded sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse #(
   parameter int WIDTH = mi_pkg::WIDTH_DEFAULT
) (
   input  wire  logic             clock,
   input  wire  logic             reset,
   input  wire  logic             csr_write,
   input  wire  logic [WIDTH-1:0] csr_wdata,
   mi_req_if.sink                 req,
   mi_rsp_if.source               rsp
);
   import mi_pkg::*;

   ucode_type  ctrl;
   status_type status;

   mi_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   mi_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .status    (status),
      .req       (req),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

// File: sim/tb_modular_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_inverse
// Self-checking bench for the modular inverse block. Each phase writes a
// modulus while the block is idle and then streams values through the
// request channel. A scoreboard runs extended Euclid on every value the
// block accepts and compares each response, in order, against the result
// computed from that value. While idling is set, the response side and the
// request side stall at random. A watchdog ends the run if transfers stop.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [mi_pkg::WIDTH_DEFAULT-1:0] value;
   logic [mi_pkg::WIDTH_DEFAULT-1:0] inverse;
   logic                             no_inverse;
} inv_answer_type;

class inverse_book;
   localparam int W = mi_pkg::WIDTH_DEFAULT;

   logic [W-1:0]   modulus;
   inv_answer_type answers[$];
   int             errors;

   function new();
      modulus = 1;
      errors  = 0;
   endfunction

   function int pending();
      return answers.size();
   endfunction

   task report(input string msg);
      errors++;
      if (errors <= 40)
         $display("%0t ERROR: %s", $realtime, msg);
   endtask

   // extended Euclid on 64-bit words, coefficients wrap like the hardware
   function inv_answer_type compute_answer(input logic [W-1:0] value);
      inv_answer_type ans;
      logic [63:0] a, b, keep, lead, q, r, t;
      ans.value      = value;
      ans.inverse    = '0;
      ans.no_inverse = 1'b0;
      if (modulus == 1) begin
         ans.inverse = 1;
      end else if (modulus == 0 || value == 0) begin
         ans.no_inverse = 1'b1;
      end else begin
         a    = 64'(value);
         b    = 64'(modulus);
         keep = 64'd0;
         lead = 64'd1;
         while (a > 64'd1 && b != 64'd0) begin
            q    = a / b;
            r    = a % b;
            t    = keep;
            a    = b;
            b    = r;
            keep = lead - q * keep;
            lead = t;
         end
         if (a != 64'd1) begin
            ans.no_inverse = 1'b1;
         end else begin
            if (lead[63])
               lead = lead + 64'(modulus);
            ans.inverse = lead[W-1:0];
         end
      end
      return ans;
   endfunction

   function void note_value(input logic [W-1:0] value);
      answers.push_back(compute_answer(value));
   endfunction

   task check_result(input logic [W-1:0] inverse, input logic no_inverse);
      inv_answer_type want;
      if (answers.size() == 0) begin
         report($sformatf("response with nothing outstanding: inverse=%h no_inverse=%b",
                          inverse, no_inverse));
      end else begin
         want = answers.pop_front();
         if (inverse !== want.inverse)
            report($sformatf("value %h mod %h: inverse %h, want %h",
                             want.value, modulus, inverse, want.inverse));
         if (no_inverse !== want.no_inverse)
            report($sformatf("value %h mod %h: no_inverse %b, want %b",
                             want.value, modulus, no_inverse, want.no_inverse));
      end
   endtask
endclass

module tb_modular_inverse;
   import mi_pkg::*;

   localparam int W          = WIDTH_DEFAULT;
   localparam int STALL_MAX  = 20000;
   localparam int PHASES     = 12;
   localparam int PER_PHASE  = 60;

   logic         clock;
   logic         reset;
   logic         csr_write;
   logic [W-1:0] csr_wdata;
   bit           idling;
   int           quiet_cycles;

   inverse_book book = new();

   mi_req_if #(.WIDTH(W)) req_ch ();
   mi_rsp_if #(.WIDTH(W)) rsp_ch ();

   modular_inverse #(.WIDTH(W)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset        = 1'b1;
      csr_write    = 1'b0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      idling       = 1'b1;
   end

   // monitors and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            book.note_value(req_ch.value);
         if (rsp_ch.valid && rsp_ch.ready)
            book.check_result(rsp_ch.inverse, rsp_ch.no_inverse);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_write)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("watchdog: no transfer for %0d cycles", STALL_MAX);
            $display("Regression FAIL");
            $finish;
         end
      end else begin
         quiet_cycles <= 0;
      end
   end

   // response side back-pressure
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (idling && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 6);
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         @(negedge clock);
      end
   end

   task automatic send_value(input logic [W-1:0] v);
      int gap;
      @(negedge clock);
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.value = v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_modulus(input logic [W-1:0] m);
      drain();
      @(negedge clock);
      csr_write = 1'b1;
      csr_wdata = m;
      @(negedge clock);
      csr_write = 1'b0;
      book.modulus = m;
   endtask

   function automatic logic [W-1:0] pick_modulus(input int phase);
      logic [W-1:0] m;
      m = $urandom;
      if (phase >= 4) begin
         case ($urandom_range(0, 6))
            0: m = $urandom_range(300, 2);
            1: m = '1;
            2: m = 32'd4294967291;
            3: m = $urandom | 32'h8000_0001;
            4: m = $urandom_range(1, 0);
            default: ;
         endcase
      end
      return m;
   endfunction

   function automatic logic [W-1:0] pick_value(input logic [W-1:0] m);
      logic [W-1:0] v;
      int           f;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = 1;
         2: v = m - 1;
         3, 4, 5: if (m > 1) v = $urandom_range(m - 1, 1);
         6: begin
            // multiple of a small factor of the modulus
            for (f = 2; f < 64; f++)
               if (m % f == 0) break;
            if (f < 64)
               v = f * $urandom_range(32'hFFFF_FFFF / f, 1);
         end
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      int p;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // modulus one out of reset
      send_value('0);
      send_value(1);
      send_value('1);
      send_value(32'd12345);

      // modulus zero has no inverses
      set_modulus('0);
      send_value('0);
      send_value(5);
      send_value('1);

      // all-ones modulus = 3*5*17*257*65537
      set_modulus('1);
      send_value('0);
      send_value(1);
      send_value(2);
      send_value(3);
      send_value('1);
      send_value(32'hFFFF_FFFE);
      send_value(32'h8000_0000);

      // consecutive Fibonacci numbers: longest Euclid chain
      set_modulus(32'd2971215073);
      send_value(32'd1836311903);
      send_value(32'd2971215074);
      send_value('1);

      set_modulus(2);
      send_value('0);
      send_value(1);
      send_value(3);

      set_modulus(12);
      send_value(6);
      send_value(5);
      send_value(13);

      for (p = 0; p < PHASES; p++) begin
         if (p >= PHASES - 2)
            idling = 1'b0;
         set_modulus(pick_modulus(p));
         repeat (PER_PHASE) send_value(pick_value(book.modulus));
      end

      drain();
      repeat (50) @(posedge clock);
      if (book.pending() != 0)
         book.report($sformatf("%0d responses never arrived", book.pending()));
      if (book.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
src/mi_pkg.sv
src/mi_if.sv
src/mi_useq.sv
src/mi_datapath.sv
src/modular_inverse.sv
sim/tb_modular_inverse.sv
